[rtl/fixed_partition_fit_allocator_assert.svh]
// Assertion macros for the partition allocator.
// FPA_ASSERT_IMPL checks cons in the same cycle as ante.
// FPA_ASSERT_NEXT checks cons in the cycle after ante.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_ASSERT_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define FPA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define FPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define FPA_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define FPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/fpa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fpa_pkg;

   // Fixed field widths of the item ports
   localparam int PART_INDEX_W = 4;
   localparam int BLOCK_SIZE_W = 16;
   localparam int WASTE_W      = 16;
   localparam int TOTAL_W      = 24;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 5;

   localparam logic [TOTAL_W-1:0]    TOTAL_MAX   = 24'hFFFFFF;
   localparam logic [CSR_DATA_W-1:0] PARTS_RESET = 5'd16;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FIT_POLICY        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PARTITIONS_IN_USE = 2'd1;

   typedef enum logic [1:0] {
      POLICY_FIRST = 2'd0,
      POLICY_NEXT  = 2'd1,
      POLICY_BEST  = 2'd2,
      POLICY_WORST = 2'd3
   } policy_type;

   typedef enum logic {
      MODE_LOAD    = 1'b0,
      MODE_REQUEST = 1'b1
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   typedef struct packed {
      mode_type                  mode;
      logic [PART_INDEX_W-1:0]   partition_index;
      logic [BLOCK_SIZE_W-1:0]   block_size;
      logic                      end_of_batch;
   } req_type;

   typedef struct packed {
      logic                      granted;
      logic [PART_INDEX_W-1:0]   granted_index;
      logic [WASTE_W-1:0]        waste;
      logic [TOTAL_W-1:0]        total_waste;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/fpa_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module fpa_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/fixed_partition_fit_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_partition_fit_allocator_assert.svh"

// Fixed-partition allocator. A load item (start high while busy is low) writes one
// partition's size and frees it; its result comes on the next cycle and busy never
// rises. A request item scans the first partitions_in_use table entries (capped at
// MAX_PARTITIONS), one table read per cycle from the partition RAM, then commits
// the grant through the drain and done states; the result strobes on rsp_valid in
// the same cycle that busy falls, and a new item can be started in that same cycle.
// Results are shown for one cycle only and cannot be held off: the receiver must
// take rsp_item whenever rsp_valid is high. Register writes are taken only while
// the block is idle and start is low.
module fixed_partition_fit_allocator #(
   parameter int MAX_PARTITIONS = 16,
   parameter int SIZE_BITS      = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  fpa_pkg::req_type                   req_item,
   output logic                               rsp_valid,
   output fpa_pkg::rsp_type                   rsp_item,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fpa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fpa_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import fpa_pkg::*;

   localparam int IDX_W      = $clog2(MAX_PARTITIONS);
   localparam int CNT_W      = $clog2(MAX_PARTITIONS + 1);
   localparam int M_W        = (CNT_W > CSR_DATA_W) ? CNT_W : CSR_DATA_W;
   localparam int SUM_W      = ((SIZE_BITS > TOTAL_W) ? SIZE_BITS : TOTAL_W) + 1;
   localparam int ENT_W      = SIZE_BITS + 1;
   localparam int LOAD_SLOTS = 2 ** PART_INDEX_W;

   // Control state
   state_type               state_ff, state_in;
   policy_type              policy_ff, policy_in;
   logic [CSR_DATA_W-1:0]   parts_ff, parts_in;
   logic [IDX_W-1:0]        rover_ff, rover_in;
   logic [TOTAL_W-1:0]      total_ff, total_in;
   logic [MAX_PARTITIONS-1:0] valid_ff, valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    eval_ff, eval_in;
   logic                    cand_found_ff, cand_found_in;

   // Payload registers
   logic [IDX_W-1:0]        pos_ff, pos_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [SIZE_BITS-1:0]    req_size_ff, req_size_in;
   logic                    req_eob_ff, req_eob_in;
   logic                    ent_vld_ff, ent_vld_in;
   logic [IDX_W-1:0]        rd_pos_ff, rd_pos_in;
   logic [IDX_W-1:0]        cand_idx_ff, cand_idx_in;
   logic [SIZE_BITS-1:0]    cand_size_ff, cand_size_in;
   rsp_type                 rsp_ff, rsp_in;

   // Combinational helpers
   logic                    accept;
   logic [M_W-1:0]          m_wide;
   logic [CNT_W-1:0]        m_eff;
   logic [IDX_W-1:0]        start_pos;
   logic [IDX_W-1:0]        pos_next;
   logic [IDX_W-1:0]        slot_lut [LOAD_SLOTS];
   logic [IDX_W-1:0]        load_slot;
   logic [SIZE_BITS-1:0]    load_size;
   logic [ENT_W-1:0]        ram_q;
   logic                    ram_we;
   logic [IDX_W-1:0]        ram_waddr;
   logic [ENT_W-1:0]        ram_wdata;
   logic                    ram_re;
   logic                    ent_busy;
   logic [SIZE_BITS-1:0]    ent_size;
   logic                    ent_fits;
   logic                    ent_take;
   logic [SIZE_BITS-1:0]    grant_waste;
   logic [SUM_W-1:0]        total_sum;
   logic [TOTAL_W-1:0]      total_sat;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !start;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Active entry count, capped at the table depth
   assign m_wide = (M_W'(parts_ff) > M_W'(MAX_PARTITIONS)) ? M_W'(MAX_PARTITIONS)
                                                           : M_W'(parts_ff);
   assign m_eff  = CNT_W'(m_wide);

   // Next fit starts at the rover when it lies inside the active entries
   assign start_pos = ((policy_ff == POLICY_NEXT) && (CNT_W'(rover_ff) < m_eff))
                      ? rover_ff : '0;
   assign pos_next  = ((CNT_W'(pos_ff) + CNT_W'(1)) < m_eff) ? (pos_ff + IDX_W'(1)) : '0;

   // Load index wraps modulo the table depth
   for (genvar gi = 0; gi < LOAD_SLOTS; gi++) begin : g_slot
      assign slot_lut[gi] = IDX_W'(gi % MAX_PARTITIONS);
   end
   assign load_slot = slot_lut[req_item.partition_index];
   assign load_size = SIZE_BITS'(req_item.block_size);

   // Entry read back from the RAM; never-loaded entries read as free, size zero
   assign ent_busy = ent_vld_ff && ram_q[SIZE_BITS];
   assign ent_size = ent_vld_ff ? ram_q[SIZE_BITS-1:0] : '0;
   assign ent_fits = !ent_busy && (ent_size >= req_size_ff);
   assign ent_take = ent_fits &&
                     (!cand_found_ff ||
                      ((policy_ff == POLICY_BEST)  && (ent_size < cand_size_ff)) ||
                      ((policy_ff == POLICY_WORST) && (ent_size > cand_size_ff)));

   // Waste and saturating total for the commit
   assign grant_waste = cand_size_ff - req_size_ff;
   assign total_sum   = SUM_W'(total_ff) + SUM_W'(grant_waste);
   assign total_sat   = (total_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(total_sum);

   // RAM port control
   assign ram_re = (state_ff == ST_SCAN);

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = load_slot;
      ram_wdata = {1'b0, load_size};
      if ((state_ff == ST_IDLE) && accept && (req_item.mode == MODE_LOAD)) begin
         ram_we = 1'b1;
      end else if ((state_ff == ST_DONE) && cand_found_ff) begin
         ram_we    = 1'b1;
         ram_waddr = cand_idx_ff;
         ram_wdata = {1'b1, cand_size_ff};
      end
   end

   fpa_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_PARTITIONS)
   ) u_part_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (pos_ff),
      .rd_data (ram_q)
   );

   // Sequencer and next-state logic
   always_comb begin
      state_in      = state_ff;
      policy_in     = policy_ff;
      parts_in      = parts_ff;
      rover_in      = rover_ff;
      total_in      = total_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = 1'b0;
      eval_in       = 1'b0;
      cand_found_in = cand_found_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      req_size_in   = req_size_ff;
      req_eob_in    = req_eob_ff;
      ent_vld_in    = ent_vld_ff;
      rd_pos_in     = rd_pos_ff;
      cand_idx_in   = cand_idx_ff;
      cand_size_in  = cand_size_ff;
      rsp_in        = rsp_ff;

      // register writes
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FIT_POLICY:        policy_in = policy_type'(csr_wdata[1:0]);
            CSR_PARTITIONS_IN_USE: parts_in  = csr_wdata;
            default: ;
         endcase
      end

      // candidate update, in the cycle after each table read
      if (eval_ff && ent_take) begin
         cand_found_in = 1'b1;
         cand_idx_in   = rd_pos_ff;
         cand_size_in  = ent_size;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_item.mode == MODE_LOAD) begin
                  valid_in[load_slot]   = 1'b1;
                  rsp_valid_in          = 1'b1;
                  rsp_in.granted        = 1'b0;
                  rsp_in.granted_index  = '0;
                  rsp_in.waste          = '0;
                  rsp_in.total_waste    = total_ff;
               end else begin
                  req_size_in   = load_size;
                  req_eob_in    = req_item.end_of_batch;
                  cand_found_in = 1'b0;
                  cnt_in        = '0;
                  pos_in        = start_pos;
                  state_in      = (m_eff == '0) ? ST_DONE : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_pos_in  = pos_ff;
            ent_vld_in = valid_ff[pos_ff];
            eval_in    = 1'b1;
            pos_in     = pos_next;
            cnt_in     = cnt_ff + CNT_W'(1);
            if ((cnt_ff + CNT_W'(1)) == m_eff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (cand_found_ff) begin
               valid_in[cand_idx_ff] = 1'b1;
               total_in              = total_sat;
               if (policy_ff == POLICY_NEXT) begin
                  rover_in = cand_idx_ff;
               end
               rsp_in.granted        = 1'b1;
               rsp_in.granted_index  = PART_INDEX_W'(cand_idx_ff);
               rsp_in.waste          = WASTE_W'(grant_waste);
               rsp_in.total_waste    = total_sat;
            end else begin
               rsp_in.granted        = 1'b0;
               rsp_in.granted_index  = '0;
               rsp_in.waste          = '0;
               rsp_in.total_waste    = total_ff;
            end
            // end of batch clears after the result is formed
            if (req_eob_ff) begin
               total_in = '0;
               rover_in = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         policy_ff     <= POLICY_FIRST;
         parts_ff      <= PARTS_RESET;
         rover_ff      <= '0;
         total_ff      <= '0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         eval_ff       <= 1'b0;
         cand_found_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         policy_ff     <= policy_in;
         parts_ff      <= parts_in;
         rover_ff      <= rover_in;
         total_ff      <= total_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         eval_ff       <= eval_in;
         cand_found_ff <= cand_found_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      cnt_ff       <= cnt_in;
      req_size_ff  <= req_size_in;
      req_eob_ff   <= req_eob_in;
      ent_vld_ff   <= ent_vld_in;
      rd_pos_ff    <= rd_pos_in;
      cand_idx_ff  <= cand_idx_in;
      cand_size_ff <= cand_size_in;
      rsp_ff       <= rsp_in;
   end

   // Checks
   `FPA_ASSERT_NEXT(a_rsp_when_due, clock, reset, (state_ff == ST_DONE) || (accept && (req_item.mode == MODE_LOAD)), rsp_valid, "result missing after commit or load")
   `FPA_ASSERT_NEXT(a_rsp_only_when_due, clock, reset, (state_ff != ST_DONE) && !(accept && (req_item.mode == MODE_LOAD)), !rsp_valid, "unexpected result strobe")
   `FPA_ASSERT_IMPL(a_scan_bound, clock, reset, state_ff == ST_SCAN, cnt_ff < m_eff, "scan ran past active entries")
   `FPA_ASSERT_IMPL(a_no_grant_fields, clock, reset, rsp_valid && !rsp_item.granted, (rsp_item.waste == '0) && (rsp_item.granted_index == '0), "ungranted result carries index or waste")

endmodule

`default_nettype wire
